// ===== design/sfcu_pkg.sv =====
// Shared types and constants for the serial flow-control unit.
package sfcu_pkg;

  // Receive buffer depth used by the stop threshold
  localparam int BUF_DEPTH = 4096;

  // Field widths
  localparam int LEVEL_W = 13;
  localparam int KIND_W  = 3;
  localparam int HOLD_W  = 5;
  localparam int PEER_W  = 3;
  localparam int FC_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Stop threshold compare width: holds fill + xoff_limit and BUF_DEPTH
  localparam int CMP_W = $clog2(BUF_DEPTH + (2 ** (LEVEL_W + 1))) + 1;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_LEVEL     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MODEM     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLOW_RX   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BREAK     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TX_ACT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLOW_SENT = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RTS_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DTR_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RECEIVE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF_CONTINUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_TRANSMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HS_MASK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_XON_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF_LIMIT    = 3'd7;

  // Line modes
  localparam logic [1:0] MODE_OFF       = 2'd0;
  localparam logic [1:0] MODE_ON        = 2'd1;
  localparam logic [1:0] MODE_HANDSHAKE = 2'd2;
  localparam logic [1:0] MODE_TOGGLE    = 2'd3;

  // Flow character codes
  localparam logic [FC_W-1:0] FC_NONE = 2'd0;
  localparam logic [FC_W-1:0] FC_XON  = 2'd1;
  localparam logic [FC_W-1:0] FC_XOFF = 2'd2;

  // Transmit hold bits
  localparam int H_CTS = 0;
  localparam int H_DSR = 1;
  localparam int H_DCD = 2;
  localparam int H_XON = 3;
  localparam int H_BRK = 4;

  // Peer hold bits
  localparam int P_RTS  = 0;
  localparam int P_DTR  = 1;
  localparam int P_XOFF = 2;

  typedef struct packed {
    logic [1:0]            rts_mode;
    logic [1:0]            dtr_mode;
    logic                  auto_receive;
    logic                  xoff_continue;
    logic                  auto_transmit;
    logic [2:0]            out_handshake_mask;
    logic [LEVEL_W-1:0]    xon_limit;
    logic [LEVEL_W-1:0]    xoff_limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] fill_level;
    logic               space_freed;
    logic               cts_in;
    logic               dsr_in;
    logic               dcd_in;
    logic               flow_char_is_xon;
    logic               break_request;
    logic               write_pending;
  } event_t;

  typedef struct packed {
    logic [HOLD_W-1:0] tx_hold;
    logic [PEER_W-1:0] peer_hold;
    logic [FC_W-1:0]   pending_flow_char;
    logic              rts_reg;
    logic              dtr_reg;
  } state_t;

  typedef struct packed {
    logic              rts_level;
    logic              rts_changed;
    logic              dtr_level;
    logic              dtr_changed;
    logic [FC_W-1:0]   flow_char_request;
    logic [HOLD_W-1:0] tx_hold_flags;
    logic [PEER_W-1:0] peer_hold_flags;
    logic              try_write;
    logic              break_active;
  } result_t;

endpackage

// ===== design/sfcu_event.sv =====
// Next-state and result logic for one flow-control event.
module sfcu_event (
  input  sfcu_pkg::cfg_t    cfg,
  input  sfcu_pkg::state_t  cur,
  input  sfcu_pkg::event_t  ev,
  output sfcu_pkg::state_t  nxt,
  output sfcu_pkg::result_t res
);
  import sfcu_pkg::*;

  logic                try_w;
  logic                rts_chg;
  logic                dtr_chg;
  logic [HOLD_W-1:0]   nh;
  logic [HOLD_W-1:0]   hold_nobrk;
  logic [CMP_W-1:0]    stop_sum;
  logic                stop_hit;
  logic                release_hit;
  logic                do_toggle;

  // Stop threshold: fill + xoff_limit > depth, no wrap
  assign stop_sum = CMP_W'(ev.fill_level) + CMP_W'(cfg.xoff_limit);
  assign stop_hit = !ev.space_freed && (stop_sum > CMP_W'(BUF_DEPTH));
  assign release_hit = ev.space_freed && (ev.fill_level <= cfg.xon_limit);

  // Modem hold recompute
  always_comb begin
    nh = cur.tx_hold;
    nh[H_CTS] = cfg.out_handshake_mask[0] && !ev.cts_in;
    nh[H_DSR] = cfg.out_handshake_mask[1] && !ev.dsr_in;
    nh[H_DCD] = cfg.out_handshake_mask[2] && !ev.dcd_in;
  end

  assign hold_nobrk = {1'b0, cur.tx_hold[H_BRK-1:0]};

  // Event dispatch
  always_comb begin
    nxt       = cur;
    try_w     = 1'b0;
    rts_chg   = 1'b0;
    dtr_chg   = 1'b0;
    do_toggle = 1'b0;
    case (ev.kind)
      KIND_LEVEL: begin
        if (cur.peer_hold == '0) begin
          if (stop_hit) begin
            if (cfg.rts_mode == MODE_HANDSHAKE) begin
              nxt.peer_hold[P_RTS] = 1'b1;
              nxt.rts_reg = 1'b0;
              rts_chg = 1'b1;
            end
            if (cfg.dtr_mode == MODE_HANDSHAKE) begin
              nxt.peer_hold[P_DTR] = 1'b1;
              nxt.dtr_reg = 1'b0;
              dtr_chg = 1'b1;
            end
            if (cfg.auto_receive) begin
              nxt.peer_hold[P_XOFF] = 1'b1;
              if (!cfg.xoff_continue) begin
                nxt.tx_hold[H_XON] = 1'b1;
              end
              nxt.pending_flow_char = FC_XOFF;
              try_w = 1'b1;
            end
          end
        end else if (release_hit) begin
          if (cfg.rts_mode == MODE_HANDSHAKE) begin
            nxt.peer_hold[P_RTS] = 1'b0;
            nxt.rts_reg = 1'b1;
            rts_chg = 1'b1;
          end
          if (cfg.dtr_mode == MODE_HANDSHAKE) begin
            nxt.peer_hold[P_DTR] = 1'b0;
            nxt.dtr_reg = 1'b1;
            dtr_chg = 1'b1;
          end
          if (cfg.auto_receive) begin
            nxt.peer_hold[P_XOFF] = 1'b0;
            nxt.tx_hold[H_XON] = 1'b0;
            nxt.pending_flow_char = FC_XON;
            try_w = 1'b1;
          end
        end
      end
      KIND_MODEM: begin
        // Retry when the last line hold other than XON goes away
        if (!nh[H_BRK] && nh[H_DCD:H_CTS] == '0 &&
            (cur.tx_hold[H_BRK] || cur.tx_hold[H_DCD:H_CTS] != '0)) begin
          if (cur.pending_flow_char != FC_NONE ||
              (nh == '0 && ev.write_pending)) begin
            try_w = 1'b1;
          end
        end
        nxt.tx_hold = nh;
      end
      KIND_FLOW_RX: begin
        if (cfg.auto_transmit) begin
          if (ev.flow_char_is_xon) begin
            if (cur.tx_hold[H_XON]) begin
              nxt.tx_hold[H_XON] = 1'b0;
              if ((cur.tx_hold & ~(HOLD_W'(1) << H_XON)) == '0 && ev.write_pending) begin
                try_w = 1'b1;
              end
            end
          end else begin
            nxt.tx_hold[H_XON] = 1'b1;
          end
        end
      end
      KIND_BREAK: begin
        if (ev.break_request) begin
          if (!cur.tx_hold[H_BRK]) begin
            nxt.tx_hold[H_BRK] = 1'b1;
            try_w = 1'b1;
          end
        end else if (cur.tx_hold[H_BRK]) begin
          nxt.tx_hold[H_BRK] = 1'b0;
          if ((hold_nobrk[H_DCD:H_CTS] == '0 && cur.pending_flow_char != FC_NONE) ||
              (hold_nobrk == '0 && ev.write_pending)) begin
            try_w = 1'b1;
          end
        end
        do_toggle = 1'b1;
      end
      KIND_TX_ACT: begin
        do_toggle = 1'b1;
      end
      KIND_FLOW_SENT: begin
        nxt.pending_flow_char = FC_NONE;
        do_toggle = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase

    // Transmit-toggle RTS follows activity after the event's updates
    if (do_toggle && cfg.rts_mode == MODE_TOGGLE) begin
      nxt.rts_reg = !nxt.tx_hold[H_BRK] &&
                    (nxt.pending_flow_char != FC_NONE || ev.write_pending);
      rts_chg = 1'b1;
    end
  end

  // Result from the updated state
  always_comb begin
    res.rts_level         = nxt.rts_reg;
    res.rts_changed       = rts_chg;
    res.dtr_level         = nxt.dtr_reg;
    res.dtr_changed       = dtr_chg;
    res.flow_char_request = nxt.pending_flow_char;
    res.tx_hold_flags     = nxt.tx_hold;
    res.peer_hold_flags   = nxt.peer_hold;
    res.try_write         = try_w;
    res.break_active      = nxt.tx_hold[H_BRK];
  end

endmodule

// ===== design/serial_flow_control_unit.sv =====
// UART flow-control unit top level: stream ports, config registers, pipeline.
// Takes one event per request and returns exactly one result per event. An event
// is registered on entry, evaluated against the flag state, and its result is
// placed in the output register; the unit accepts a new event every cycle while
// results are taken, for a throughput of one event per cycle. A stalled result
// holds the entry register, which still takes one further event. Configuration
// writes (index 0..7 in the order rts_mode, dtr_mode, auto_receive, xoff_continue,
// auto_transmit, out_handshake_mask, xon_limit, xoff_limit) take effect at the next
// edge and should be made while no event is in flight.
module serial_flow_control_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [sfcu_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sfcu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // event stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [12:0] fill_level, [13] space_freed, [14] cts_in, [15] dsr_in, [16] dcd_in,
  // [17] flow_char_is_xon, [18] break_request, [19] write_pending, [23:20] zero
  input  logic [23:0]                   in_tdata,
  // [2:0] kind
  input  logic [2:0]                    in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] rts_level, [1] rts_changed, [2] dtr_level, [3] dtr_changed,
  // [5:4] flow_char_request, [10:6] tx_hold_flags, [13:11] peer_hold_flags,
  // [14] try_write, [15] break_active
  output logic [15:0]                   out_tdata
);
  import sfcu_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  state_t  state_r, state_nxt;
  event_t  ev_r;
  logic    ev_v_r;
  result_t res_r;
  result_t res_nxt;
  logic    out_v_r;
  logic    advance;
  event_t  ev_in;

  // Unpack the incoming request
  always_comb begin
    ev_in.kind             = in_tuser;
    ev_in.fill_level       = in_tdata[12:0];
    ev_in.space_freed      = in_tdata[13];
    ev_in.cts_in           = in_tdata[14];
    ev_in.dsr_in           = in_tdata[15];
    ev_in.dcd_in           = in_tdata[16];
    ev_in.flow_char_is_xon = in_tdata[17];
    ev_in.break_request    = in_tdata[18];
    ev_in.write_pending    = in_tdata[19];
  end

  // Pipeline control
  assign advance   = ev_v_r && (!out_v_r || out_tready);
  assign in_tready = !ev_v_r || advance;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_RTS_MODE:      cfg_nxt.rts_mode = cfg_wdata[1:0];
        REG_DTR_MODE:      cfg_nxt.dtr_mode = cfg_wdata[1:0];
        REG_AUTO_RECEIVE:  cfg_nxt.auto_receive = cfg_wdata[0];
        REG_XOFF_CONTINUE: cfg_nxt.xoff_continue = cfg_wdata[0];
        REG_AUTO_TRANSMIT: cfg_nxt.auto_transmit = cfg_wdata[0];
        REG_OUT_HS_MASK:   cfg_nxt.out_handshake_mask = cfg_wdata[2:0];
        REG_XON_LIMIT:     cfg_nxt.xon_limit = cfg_wdata[LEVEL_W-1:0];
        REG_XOFF_LIMIT:    cfg_nxt.xoff_limit = cfg_wdata[LEVEL_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Event evaluation
  sfcu_event u_event (
    .cfg (cfg_r),
    .cur (state_r),
    .ev  (ev_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      state_r <= '0;
      ev_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (in_tready) begin
        ev_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r <= ev_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Pack the result
  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r.break_active, res_r.try_write, res_r.peer_hold_flags,
                       res_r.tx_hold_flags, res_r.flow_char_request,
                       res_r.dtr_changed, res_r.dtr_level,
                       res_r.rts_changed, res_r.rts_level};

endmodule

// ===== tb/sfcu_flow_checker.sv =====
// Result checker for the serial flow-control unit: predicts each result and compares.
module sfcu_flow_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfcu_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sfcu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [12:0] fill_level, [13] space_freed, [14] cts_in, [15] dsr_in, [16] dcd_in,
  // [17] flow_char_is_xon, [18] break_request, [19] write_pending, [23:20] zero
  input  logic [23:0]                     in_tdata,
  // [2:0] kind
  input  logic [2:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] rts_level, [1] rts_changed, [2] dtr_level, [3] dtr_changed,
  // [5:4] flow_char_request, [10:6] tx_hold_flags, [13:11] peer_hold_flags,
  // [14] try_write, [15] break_active
  input  logic [15:0]                     out_tdata,
  output int                              mismatch_count,
  output int                              awaiting,
  output int                              checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfcu_pkg::*;

  // The XON hold bit alone; its complement selects every other hold bit
  localparam logic [HOLD_W-1:0] XON_MASK = HOLD_W'(1) << H_XON;

  // Shadow of the register file and of the flag state
  cfg_t               cfg_shadow;
  logic [HOLD_W-1:0]  hold_tx;
  logic [PEER_W-1:0]  hold_peer;
  logic [FC_W-1:0]    flow_pending;
  logic               rts_drv;
  logic               dtr_drv;

  result_t            expected_results[$];
  result_t            want;
  result_t            got;
  logic               bad;
  int                 mism_cnt = 0;
  int                 n_checked = 0;

  // Transmit-toggle drive of RTS; returns whether RTS was driven
  function automatic logic toggle_rts(input logic wp);
    if (cfg_shadow.rts_mode != MODE_TOGGLE) return 1'b0;
    rts_drv = !hold_tx[H_BRK] && (flow_pending != FC_NONE || wp);
    return 1'b1;
  endfunction

  // Apply one event to the shadow state and build the result it produces
  function automatic result_t predict_flow_result(input logic [KIND_W-1:0] kind,
                                                  input logic [23:0] d);
    logic [LEVEL_W-1:0] fill;
    logic               freed, cts, dsr, dcd, is_xon, brk, wp;
    logic [HOLD_W-1:0]  nh;
    logic               try_p, rts_chg, dtr_chg;
    result_t            r;
    fill   = d[12:0];
    freed  = d[13];
    cts    = d[14];
    dsr    = d[15];
    dcd    = d[16];
    is_xon = d[17];
    brk    = d[18];
    wp     = d[19];
    try_p   = 1'b0;
    rts_chg = 1'b0;
    dtr_chg = 1'b0;
    case (kind)
      KIND_LEVEL: begin
        if (hold_peer == '0) begin
          // stop the peer once free space drops under the XOFF limit
          if (!freed && (int'(fill) + int'(cfg_shadow.xoff_limit) > BUF_DEPTH)) begin
            if (cfg_shadow.rts_mode == MODE_HANDSHAKE) begin
              hold_peer[P_RTS] = 1'b1;
              rts_drv = 1'b0;
              rts_chg = 1'b1;
            end
            if (cfg_shadow.dtr_mode == MODE_HANDSHAKE) begin
              hold_peer[P_DTR] = 1'b1;
              dtr_drv = 1'b0;
              dtr_chg = 1'b1;
            end
            if (cfg_shadow.auto_receive) begin
              hold_peer[P_XOFF] = 1'b1;
              if (!cfg_shadow.xoff_continue) hold_tx[H_XON] = 1'b1;
              flow_pending = FC_XOFF;
              try_p = 1'b1;
            end
          end
        end else if (freed && fill <= cfg_shadow.xon_limit) begin
          // release the peer
          if (cfg_shadow.rts_mode == MODE_HANDSHAKE) begin
            hold_peer[P_RTS] = 1'b0;
            rts_drv = 1'b1;
            rts_chg = 1'b1;
          end
          if (cfg_shadow.dtr_mode == MODE_HANDSHAKE) begin
            hold_peer[P_DTR] = 1'b0;
            dtr_drv = 1'b1;
            dtr_chg = 1'b1;
          end
          if (cfg_shadow.auto_receive) begin
            hold_peer[P_XOFF] = 1'b0;
            hold_tx[H_XON] = 1'b0;
            flow_pending = FC_XON;
            try_p = 1'b1;
          end
        end
      end
      KIND_MODEM: begin
        nh = hold_tx;
        nh[H_CTS] = cfg_shadow.out_handshake_mask[0] & ~cts;
        nh[H_DSR] = cfg_shadow.out_handshake_mask[1] & ~dsr;
        nh[H_DCD] = cfg_shadow.out_handshake_mask[2] & ~dcd;
        // last non-XON hold just went away
        if ((nh & ~XON_MASK) == '0 && (hold_tx & ~XON_MASK) != '0) begin
          if (flow_pending != FC_NONE || (nh == '0 && wp)) try_p = 1'b1;
        end
        hold_tx = nh;
      end
      KIND_FLOW_RX: begin
        if (cfg_shadow.auto_transmit) begin
          if (is_xon) begin
            if (hold_tx[H_XON]) begin
              hold_tx[H_XON] = 1'b0;
              if (hold_tx == '0 && wp) try_p = 1'b1;
            end
          end else begin
            hold_tx[H_XON] = 1'b1;
          end
        end
      end
      KIND_BREAK: begin
        if (brk) begin
          if (!hold_tx[H_BRK]) begin
            hold_tx[H_BRK] = 1'b1;
            try_p = 1'b1;
          end
        end else if (hold_tx[H_BRK]) begin
          hold_tx[H_BRK] = 1'b0;
          if (((hold_tx & ~XON_MASK) == '0 && flow_pending != FC_NONE) ||
              (hold_tx == '0 && wp)) try_p = 1'b1;
        end
        rts_chg = toggle_rts(wp);
      end
      KIND_TX_ACT: begin
        rts_chg = toggle_rts(wp);
      end
      KIND_FLOW_SENT: begin
        flow_pending = FC_NONE;
        rts_chg = toggle_rts(wp);
      end
      default: begin
        // unused kinds leave the state alone
      end
    endcase
    r.rts_level         = rts_drv;
    r.rts_changed       = rts_chg;
    r.dtr_level         = dtr_drv;
    r.dtr_changed       = dtr_chg;
    r.flow_char_request = flow_pending;
    r.tx_hold_flags     = hold_tx;
    r.peer_hold_flags   = hold_peer;
    r.try_write         = try_p;
    r.break_active      = hold_tx[H_BRK];
    return r;
  endfunction

  function automatic result_t unpack_result(input logic [15:0] d);
    result_t r;
    r.rts_level         = d[0];
    r.rts_changed       = d[1];
    r.dtr_level         = d[2];
    r.dtr_changed       = d[3];
    r.flow_char_request = d[5:4];
    r.tx_hold_flags     = d[10:6];
    r.peer_hold_flags   = d[13:11];
    r.try_write         = d[14];
    r.break_active      = d[15];
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("rts=%b/%b dtr=%b/%b fc=%0d hold=%b peer=%b try=%b brk=%b",
                     r.rts_level, r.rts_changed, r.dtr_level, r.dtr_changed,
                     r.flow_char_request, r.tx_hold_flags, r.peer_hold_flags,
                     r.try_write, r.break_active);
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_shadow   = '0;
      hold_tx      = '0;
      hold_peer    = '0;
      flow_pending = FC_NONE;
      rts_drv      = 1'b0;
      dtr_drv      = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RTS_MODE:      cfg_shadow.rts_mode           = cfg_wdata[1:0];
          REG_DTR_MODE:      cfg_shadow.dtr_mode           = cfg_wdata[1:0];
          REG_AUTO_RECEIVE:  cfg_shadow.auto_receive       = cfg_wdata[0];
          REG_XOFF_CONTINUE: cfg_shadow.xoff_continue      = cfg_wdata[0];
          REG_AUTO_TRANSMIT: cfg_shadow.auto_transmit      = cfg_wdata[0];
          REG_OUT_HS_MASK:   cfg_shadow.out_handshake_mask = cfg_wdata[2:0];
          REG_XON_LIMIT:     cfg_shadow.xon_limit          = cfg_wdata[12:0];
          REG_XOFF_LIMIT:    cfg_shadow.xoff_limit         = cfg_wdata[12:0];
          default: ;
        endcase
      end

      // compare an accepted result with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata);
        if (expected_results.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10) $display("Result with nothing pending: %s", show(got));
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          bad = (got.rts_level         !== want.rts_level)         ||
                (got.rts_changed       !== want.rts_changed)       ||
                (got.dtr_level         !== want.dtr_level)         ||
                (got.dtr_changed       !== want.dtr_changed)       ||
                (got.flow_char_request !== want.flow_char_request) ||
                (got.tx_hold_flags     !== want.tx_hold_flags)     ||
                (got.peer_hold_flags   !== want.peer_hold_flags)   ||
                (got.try_write         !== want.try_write)         ||
                (got.break_active      !== want.break_active);
          if (bad) begin
            mism_cnt++;
            if (mism_cnt <= 10) begin
              $display("Mismatch on result %0d: expected %s", n_checked, show(want));
              $display("                     actual   %s", show(got));
            end
          end
        end
      end

      if (in_tvalid && in_tready)
        expected_results.push_back(predict_flow_result(in_tuser, in_tdata));
    end
    awaiting       <= expected_results.size();
    mismatch_count <= mism_cnt;
    checked_count  <= n_checked;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the flow-control unit bench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 92;
  localparam int NUM_PHASES  = 8;

  // Kinds the unit ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata  = '0;
  logic [2:0]            in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;

  int   mismatch_count;
  int   awaiting;
  int   checked_count;
  int   cycle_count   = 0;
  int   items_sent    = 0;
  int   settings_used = 0;
  int   burst_left    = 0;
  int   ready_pct     = 100;
  int   stall_span    = 0;
  cfg_t cur_cfg;

  serial_flow_control_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sfcu_flow_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .awaiting       (awaiting),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random readiness, with the readiness level redrawn when its span runs out
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0, 1:    ready_pct <= 100;
        2:       ready_pct <= 70;
        3:       ready_pct <= 35;
        default: ready_pct <= 8;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    out_tready <= ($urandom_range(1, 100) <= ready_pct);
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, awaiting);
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    cur_cfg = c;
    settings_used++;
    write_reg(REG_RTS_MODE,      CFG_DATA_W'(c.rts_mode));
    write_reg(REG_DTR_MODE,      CFG_DATA_W'(c.dtr_mode));
    write_reg(REG_AUTO_RECEIVE,  CFG_DATA_W'(c.auto_receive));
    write_reg(REG_XOFF_CONTINUE, CFG_DATA_W'(c.xoff_continue));
    write_reg(REG_AUTO_TRANSMIT, CFG_DATA_W'(c.auto_transmit));
    write_reg(REG_OUT_HS_MASK,   CFG_DATA_W'(c.out_handshake_mask));
    write_reg(REG_XON_LIMIT,     c.xon_limit);
    write_reg(REG_XOFF_LIMIT,    c.xoff_limit);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 13'd8191;
      2:       return LEVEL_W'($urandom_range(0, BUF_DEPTH));
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Register settings per phase: a few fixed corners, then random ones
  function automatic cfg_t phase_settings(input int p);
    cfg_t c;
    c = '0;
    case (p)
      0: begin
        c.rts_mode = MODE_HANDSHAKE;  c.dtr_mode = MODE_HANDSHAKE;
        c.auto_receive = 1'b1;        c.auto_transmit = 1'b1;
        c.out_handshake_mask = 3'd7;  c.xon_limit = 13'd1000;  c.xoff_limit = 13'd100;
      end
      1: begin
        c.rts_mode = MODE_TOGGLE;     c.dtr_mode = MODE_ON;
        c.auto_receive = 1'b1;        c.xoff_continue = 1'b1;  c.auto_transmit = 1'b1;
        c.out_handshake_mask = 3'd5;  c.xon_limit = 13'd0;     c.xoff_limit = 13'd0;
      end
      2: begin
        // code 3 on DTR: no handshake
        c.rts_mode = MODE_OFF;        c.dtr_mode = MODE_TOGGLE;
        c.xon_limit = 13'd8191;       c.xoff_limit = 13'd8191;
      end
      3: begin
        c.rts_mode = MODE_ON;         c.dtr_mode = MODE_HANDSHAKE;
        c.auto_receive = 1'b1;        c.auto_transmit = 1'b1;
        c.out_handshake_mask = 3'd3;  c.xon_limit = 13'd4096;  c.xoff_limit = 13'd4096;
      end
      4: begin
        c.rts_mode = MODE_TOGGLE;     c.dtr_mode = MODE_HANDSHAKE;
        c.auto_receive = 1'b1;        c.xoff_continue = 1'b1;
        c.out_handshake_mask = 3'd6;  c.xon_limit = 13'd4095;  c.xoff_limit = 13'd1;
      end
      default: begin
        c.rts_mode           = 2'($urandom_range(0, 3));
        c.dtr_mode           = 2'($urandom_range(0, 3));
        c.auto_receive       = 1'($urandom_range(0, 1));
        c.xoff_continue      = 1'($urandom_range(0, 1));
        c.auto_transmit      = 1'($urandom_range(0, 1));
        c.out_handshake_mask = 3'($urandom_range(0, 7));
        c.xon_limit          = pick_limit();
        c.xoff_limit         = pick_limit();
      end
    endcase
    return c;
  endfunction

  function automatic logic [23:0] event_tdata(input event_t e);
    return {4'b0, e.write_pending, e.break_request, e.flow_char_is_xon,
            e.dcd_in, e.dsr_in, e.cts_in, e.space_freed, e.fill_level};
  endfunction

  // flags: {space_freed, cts, dsr, dcd, flow_char_is_xon, break_request, write_pending}
  function automatic event_t mk_event(input logic [KIND_W-1:0] kind,
                                      input logic [LEVEL_W-1:0] fill,
                                      input logic [6:0] flags);
    return {kind, fill, flags};
  endfunction

  function automatic event_t random_event();
    logic [31:0] r;
    event_t      e;
    r = $urandom;
    e = r[$bits(event_t)-1:0];
    return e;
  endfunction

  // Fill around the stop threshold, one short of it included
  function automatic logic [LEVEL_W-1:0] stop_fill();
    int t;
    t = BUF_DEPTH - int'(cur_cfg.xoff_limit) + $urandom_range(0, 4);
    if (t < 0) t = $urandom_range(0, 64);
    if (t > 8191) t = 8191;
    return LEVEL_W'(t);
  endfunction

  // Fill at or under the release level, now and then one above
  function automatic logic [LEVEL_W-1:0] release_fill();
    int t;
    if ($urandom_range(0, 4) == 0) t = int'(cur_cfg.xon_limit) + 1;
    else t = $urandom_range(0, int'(cur_cfg.xon_limit));
    if (t > 8191) t = 8191;
    return LEVEL_W'(t);
  endfunction

  function automatic event_t noise_event();
    event_t e;
    e = random_event();
    if (e.kind > KIND_FLOW_SENT && $urandom_range(0, 3) != 0)
      e.kind = KIND_W'($urandom_range(KIND_LEVEL, KIND_FLOW_SENT));
    if (e.kind == KIND_LEVEL && $urandom_range(0, 1))
      e.fill_level = e.space_freed ? release_fill() : stop_fill();
    return e;
  endfunction

  // One request; starts a new burst, maybe after a gap, when the last one ran out
  task automatic send_event(input event_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= event_tdata(e);
    in_tuser  <= e.kind;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop the peer, do some traffic, release it, maybe report the flow char sent
  task automatic run_episode();
    event_t e;
    int     k;
    e = random_event();
    e.kind = KIND_LEVEL;
    e.space_freed = 1'b0;
    e.fill_level = stop_fill();
    send_event(e);
    k = $urandom_range(0, 4);
    repeat (k) send_event(noise_event());
    e = random_event();
    e.kind = KIND_LEVEL;
    e.space_freed = 1'b1;
    e.fill_level = release_fill();
    send_event(e);
    if ($urandom_range(0, 1)) begin
      e = random_event();
      e.kind = KIND_FLOW_SENT;
      send_event(e);
    end
  endtask

  task automatic run_random_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) != 0) run_episode();
      else send_event(noise_event());
    end
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Corners under phase 0 settings: XOFF limit 100, XON limit 1000
  task automatic run_directed();
    send_event(mk_event(KIND_LEVEL,     13'd0,    7'b0000000));
    send_event(mk_event(KIND_LEVEL,     13'd3996, 7'b0000000)); // one under stop
    send_event(mk_event(KIND_LEVEL,     13'd3997, 7'b0000000)); // stop
    send_event(mk_event(KIND_LEVEL,     13'd8191, 7'b0111111)); // already held
    send_event(mk_event(KIND_MODEM,     13'd0,    7'b0000001)); // all lines low
    send_event(mk_event(KIND_MODEM,     13'd0,    7'b0111001)); // lines back
    send_event(mk_event(KIND_FLOW_RX,   13'd0,    7'b0000000)); // XOFF received
    send_event(mk_event(KIND_FLOW_RX,   13'd0,    7'b0000101)); // XON received
    send_event(mk_event(KIND_BREAK,     13'd0,    7'b0000011)); // break on
    send_event(mk_event(KIND_BREAK,     13'd0,    7'b0000011)); // break on again
    send_event(mk_event(KIND_TX_ACT,    13'd0,    7'b0000001));
    send_event(mk_event(KIND_BREAK,     13'd0,    7'b0000001)); // break off
    send_event(mk_event(KIND_FLOW_SENT, 13'd0,    7'b0000000));
    send_event(mk_event(KIND_LEVEL,     13'd1001, 7'b1000000)); // one above release
    send_event(mk_event(KIND_LEVEL,     13'd1000, 7'b1000000)); // release
    send_event(mk_event(KIND_LEVEL,     13'd8191, 7'b1000000)); // freed, not held
    send_event(mk_event(KIND_SPARE_6,   13'd8191, 7'b1111111));
    send_event(mk_event(KIND_SPARE_7,   13'd0,    7'b0000000));
    send_event(mk_event(KIND_LEVEL,     13'd8191, 7'b0000000)); // stop at top fill
    send_event(mk_event(KIND_LEVEL,     13'd0,    7'b1000000)); // release from empty
    send_event(mk_event(KIND_BREAK,     13'd0,    7'b0000000)); // off without break
    send_event(mk_event(KIND_FLOW_SENT, 13'd0,    7'b0000001));
  endtask

  // Stimulus and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(phase_settings(0));
    run_directed();
    run_random_phase(PHASE_ITEMS);
    drain();

    for (int p = 1; p < NUM_PHASES; p++) begin
      load_settings(phase_settings(p));
      run_random_phase(PHASE_ITEMS);
      drain();
    end

    $display("Summary: %0d events under %0d register settings, %0d results compared",
             items_sent, settings_used, checked_count);
    $display("Summary: %0d mismatches, %0d results still outstanding",
             mismatch_count, awaiting);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfcu_pkg.sv
design/sfcu_event.sv
design/serial_flow_control_unit.sv
tb/sfcu_flow_checker.sv
tb/testbench.sv
